// ===== rtl/core/lires_pkg.sv =====
// lires_pkg: shared constants, types and helpers of the resampler
`timescale 1ns / 1ps

package lires_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int OUT_W    = 16;
    localparam int RATE_W   = 17;
    localparam int WHOLE_W  = 3;
    localparam int CNT_W    = 5;
    localparam int NUM_W    = 34;
    localparam int MAG_W    = 32;
    localparam int POS_W    = 20;
    localparam int DCNT_W   = 5;

    // source rate and limits
    localparam logic [RATE_W-1:0] SRC_RATE   = 17'd9009;
    localparam logic [RATE_W-1:0] RATE_MIN   = 17'd4000;
    localparam logic [RATE_W-1:0] RATE_MAX   = 17'd96000;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
    localparam logic [CNT_W-1:0]  MAX_OUT    = 5'd22;
    localparam logic [DCNT_W-1:0] DIV_LAST   = 5'd31;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_STEP,
        ST_ADV,
        ST_PUSH,
        ST_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic div_init;
        logic div_step;
        logic step;
        logic adv;
        logic push;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cond_ok;
        logic div_last;
        logic adv_done;
        logic slot_free;
    } t_stat;

    // limit the programmed rate to the supported range
    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] res;
        if (v < RATE_MIN) begin
            res = RATE_MIN;
        end else if (v > RATE_MAX) begin
            res = RATE_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lires_if.sv =====
// lires_if: valid/ready channel interfaces for source beats and result beats
`timescale 1ns / 1ps

interface lires_in_if;
    logic                          valid;
    logic                          ready;
    logic [lires_pkg::SAMPLE_W-1:0] sample_in;
    logic                          sound_end;

    modport source (output valid, output sample_in, output sound_end, input ready);
    modport sink   (input valid, input sample_in, input sound_end, output ready);
endinterface

interface lires_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [lires_pkg::OUT_W-1:0] out_sample;
    logic                             run_last;
    logic                             sound_last;

    modport source (output valid, output out_sample, output run_last, output sound_last,
                    input ready);
    modport sink   (input valid, input out_sample, input run_last, input sound_last,
                    output ready);
endinterface

// ===== rtl/core/lires_ctrl.sv =====
// lires_ctrl: sequencer that walks one source beat through its output samples
`timescale 1ns / 1ps

module lires_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lires_pkg::t_stat  i_stat,
    output lires_pkg::t_cmd   o_cmd
);
    import lires_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.cond_ok ? ST_MUL_A : ST_FINISH;
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SUM;
            ST_SUM:   n_state = ST_ABS;
            ST_ABS:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP:  n_state = ST_ADV;
            ST_ADV: begin
                if (i_stat.adv_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_stat.slot_free) begin
                    n_state = i_stat.cond_ok ? ST_MUL_A : ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK:  o_cmd = '0;
            ST_MUL_A:  o_cmd.mul_a    = 1'b1;
            ST_MUL_B:  o_cmd.mul_b    = 1'b1;
            ST_SUM:    o_cmd.sum      = 1'b1;
            ST_ABS:    o_cmd.div_init = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_STEP:   o_cmd.step     = 1'b1;
            ST_ADV:    o_cmd.adv      = 1'b1;
            ST_PUSH:   o_cmd.push     = 1'b1;
            ST_FINISH: o_cmd.finish   = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/lires_dpath.sv =====
// lires_dpath: stream state, phase tracking, interpolation multiplier, divider, output register
`timescale 1ns / 1ps

module lires_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lires_pkg::RATE_W-1:0]        i_cfg_wdata,
    input  logic [lires_pkg::SAMPLE_W-1:0]      i_sample_in,
    input  logic                                i_sound_end,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [lires_pkg::OUT_W-1:0]  o_out_sample,
    output logic                                o_run_last,
    output logic                                o_sound_last,
    input  lires_pkg::t_cmd                     i_cmd,
    output lires_pkg::t_stat                    o_stat
);
    import lires_pkg::*;

    // configuration and stream state
    logic [RATE_W-1:0]   r_rate;
    logic                r_have_prev;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] r_older;
    logic [RATE_W-1:0]   r_pres;
    logic [1:0]          r_pwhole;

    // working state of the current beat
    logic [SAMPLE_W-1:0] r_x;
    logic                r_last;
    logic [WHOLE_W-1:0]  r_w;
    logic [RATE_W-1:0]   r_r;
    logic [CNT_W-1:0]    r_n;

    // arithmetic
    logic signed [NUM_W-1:0] r_prod;
    logic signed [NUM_W-1:0] r_num;
    logic [MAG_W-1:0]        r_div;
    logic [RATE_W-1:0]       r_rem;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_neg;

    // output register
    logic                    r_ov;
    logic signed [OUT_W-1:0] r_osample;
    logic                    r_orun;
    logic                    r_osnd;

    logic [SAMPLE_W-1:0]     sel_a;
    logic [SAMPLE_W-1:0]     sel_b;
    logic signed [OUT_W-1:0] cur_s;
    logic signed [OUT_W-1:0] nxt_s;
    logic signed [OUT_W-1:0] mul_s;
    logic [RATE_W-1:0]       mul_u;
    logic signed [NUM_W-1:0] prod;
    logic [POS_W-1:0]        pos_end;
    logic [POS_W-1:0]        limit;
    logic                    cond;
    logic [NUM_W-1:0]        mag;
    logic [RATE_W:0]         trial;
    logic                    trial_ge;
    logic [RATE_W:0]         step_sum;
    logic [OUT_W-1:0]        quot;
    logic [WHOLE_W-1:0]      w_m1;
    logic                    slot_free;

    // pick the two source samples around the output position
    always_comb begin
        case (r_w)
            3'd0: begin
                sel_a = r_older;
                sel_b = r_prev;
            end
            3'd1: begin
                sel_a = r_prev;
                sel_b = r_x;
            end
            default: begin
                sel_a = r_x;
                sel_b = r_x;
            end
        endcase
    end

    // (x - 128) << 8
    assign cur_s = $signed({~sel_a[SAMPLE_W-1], sel_a[SAMPLE_W-2:0], 8'h00});
    assign nxt_s = $signed({~sel_b[SAMPLE_W-1], sel_b[SAMPLE_W-2:0], 8'h00});

    // shared multiplier: cur*(R-r) then next*r
    assign mul_s = i_cmd.mul_a ? cur_s : nxt_s;
    assign mul_u = i_cmd.mul_a ? (r_rate - r_r) : r_r;
    assign prod  = NUM_W'(mul_s) * NUM_W'($signed({1'b0, mul_u}));

    // emit condition: position plus one step stays within the known length, and the result count stays under MAX_OUT
    assign pos_end = POS_W'(r_w) * POS_W'(r_rate) + POS_W'(r_r) + POS_W'(SRC_RATE);
    assign limit   = r_last ? (POS_W'({r_rate, 1'b0}) + POS_W'(r_rate))
                            : POS_W'({r_rate, 2'b00});
    assign cond    = (r_last || (r_w < 3'd2)) && (pos_end <= limit) && (r_n < MAX_OUT);

    // restoring divider step, one quotient bit per cycle
    assign mag      = r_num[NUM_W-1] ? (-r_num) : r_num;
    assign trial    = {r_rem, r_div[MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, r_rate});
    assign quot     = r_div[OUT_W-1:0];

    assign w_m1      = r_w - 3'd1;
    assign slot_free = !r_ov || i_out_ready;

    // configuration and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_older     <= '0;
            r_pres      <= '0;
            r_pwhole    <= '0;
        end else if (i_cfg_we) begin
            r_rate      <= clamp_rate(i_cfg_wdata);
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_older     <= '0;
            r_pres      <= '0;
            r_pwhole    <= '0;
        end else if (i_cmd.finish) begin
            if (r_last) begin
                r_have_prev <= 1'b0;
                r_prev      <= '0;
                r_older     <= '0;
                r_pres      <= '0;
                r_pwhole    <= '0;
            end else begin
                r_have_prev <= 1'b1;
                r_older     <= r_prev;
                r_prev      <= r_x;
                r_pres      <= r_r;
                r_pwhole    <= (r_w == 3'd0) ? 2'd0 : w_m1[1:0];
            end
        end
    end

    // beat working state: position, count
    assign step_sum = {1'b0, r_r} + {1'b0, SRC_RATE};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample_in;
            r_last <= i_sound_end;
            r_w    <= r_have_prev ? {1'b0, r_pwhole} : 3'd2;
            r_r    <= r_have_prev ? r_pres : '0;
            r_n    <= '0;
        end else if (i_cmd.step) begin
            r_r <= step_sum[RATE_W-1:0];
            r_n <= r_n + 5'd1;
        end else if (i_cmd.adv && (r_r >= r_rate)) begin
            r_r <= r_r - r_rate;
            r_w <= r_w + 3'd1;
        end
    end

    // products and numerator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_b) begin
            r_num <= r_prod;
        end else if (i_cmd.sum) begin
            r_num <= r_num + r_prod;
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div  <= mag[MAG_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
            r_neg  <= r_num[NUM_W-1];
        end else if (i_cmd.div_step) begin
            r_div  <= {r_div[MAG_W-2:0], trial_ge};
            r_rem  <= trial_ge ? RATE_W'(trial - {1'b0, r_rate}) : trial[RATE_W-1:0];
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push && slot_free) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && slot_free) begin
            r_osample <= r_neg ? $signed(~quot + 16'd1) : $signed(quot);
            r_orun    <= !cond;
            r_osnd    <= !cond && r_last;
        end
    end

    assign o_stat.cond_ok   = cond;
    assign o_stat.div_last  = (r_dcnt == DIV_LAST);
    assign o_stat.adv_done  = (r_r < r_rate);
    assign o_stat.slot_free = slot_free;

    assign o_out_valid  = r_ov;
    assign o_out_sample = r_osample;
    assign o_run_last   = r_orun;
    assign o_sound_last = r_osnd;

endmodule

// ===== rtl/core/linear_interp_audio_resampler.sv =====
// linear_interp_audio_resampler: top level of the 8-bit to 16-bit linear resampler
`timescale 1ns / 1ps
//
// Usage
//   i_src  : source beats, one unsigned 8-bit sample at 9009 Hz plus sound_end
//            on the last sample of a sound.
//   o_res  : result beats, signed 16-bit interpolated samples; run_last marks
//            the last result caused by one source beat, sound_last the final
//            result of the sound. A source beat may cause zero to 22 results.
//   i_cfg_we / i_cfg_wdata : output rate in Hz, clamped to 4000..96000.
//            A write drops the sound in progress; write only while idle.
// Operation
//   One source beat is worked on at a time. Each result passes through the
//   two-pass multiply, the sum, the sign fold, the radix-2 divider (one
//   quotient bit per step) and up to three phase subtractions.
//   i_src.ready is high only while the sequencer is idle.
// Reset and stall
//   Synchronous active-low reset sets the rate to 44100 Hz and starts a new
//   sound. A stalled receiver holds the result register; the sequencer waits
//   with the next result until the register frees, so nothing is lost.

module linear_interp_audio_resampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lires_in_if.sink                       i_src,
    lires_out_if.source                    o_res,
    input  logic                           i_cfg_we,
    input  logic [lires_pkg::RATE_W-1:0]   i_cfg_wdata
);
    import lires_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    lires_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_src.valid),
        .o_in_ready (i_src.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    lires_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_src.sample_in),
        .i_sound_end  (i_src.sound_end),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_out_sample (o_res.out_sample),
        .o_run_last   (o_res.run_last),
        .o_sound_last (o_res.sound_last),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule

// ===== rtl/core/lires_checker.sv =====
// lires_checker: port-level assertions for the resampler and their bind
`timescale 1ns / 1ps

module lires_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [lires_pkg::OUT_W-1:0] i_out_sample,
    input logic                               i_run_last,
    input logic                               i_sound_last
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // the sound's final result always closes a run
    a_sound_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sound_last |-> i_run_last)
        else $error("sound_last without run_last");

    // one source beat at a time: accepting a beat closes the input
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second source beat taken while busy");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample)
            && $stable(i_run_last) && $stable(i_sound_last))
        else $error("stalled result beat changed");

endmodule

bind linear_interp_audio_resampler lires_checker u_lires_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_src.valid),
    .i_in_ready   (i_src.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_sample (o_res.out_sample),
    .i_run_last   (o_res.run_last),
    .i_sound_last (o_res.sound_last)
);
